// ===== design/bcu_pkg.sv =====
package bcu_pkg;

   localparam int N_W     = 7;
   localparam int VALUE_W = 63;
   localparam int STEP_W  = 6;
   localparam int DEN_W   = STEP_W;
   localparam int WIDE_W  = VALUE_W + N_W;
   localparam int CNT_W   = $clog2(WIDE_W);

   localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

   typedef logic [VALUE_W-1:0] value_type;
   typedef logic [WIDE_W-1:0]  wide_type;
   typedef logic [DEN_W-1:0]   den_type;

endpackage

// ===== design/bcu_divider.sv =====
module bcu_divider
   import bcu_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     div_start,
   input  wide_type div_dividend,
   input  den_type  div_divisor,
   output logic     div_done,
   output wide_type div_quotient
);

   logic             running_ff, running_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   wide_type         quo_ff, quo_in;
   den_type          rem_ff, rem_in;
   den_type          divisor_ff, divisor_in;
   logic [DEN_W:0]   trial;
   den_type          trial_diff;
   logic             fits;
   logic             last;

   // One quotient bit a cycle, restoring form. The dividend shifts out of the
   // top of quo_ff while quotient bits shift in at the bottom.
   always_comb begin
      trial      = {rem_ff, quo_ff[WIDE_W-1]};
      trial_diff = trial[DEN_W-1:0] - divisor_ff;
      fits       = trial >= {1'b0, divisor_ff};
      last       = count_ff == CNT_W'(WIDE_W - 1);

      running_in = running_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;

      if (div_start) begin
         running_in = 1'b1;
         count_in   = '0;
         quo_in     = div_dividend;
         rem_in     = '0;
         divisor_in = div_divisor;
      end else if (running_ff) begin
         quo_in   = {quo_ff[WIDE_W-2:0], fits};
         rem_in   = fits ? trial_diff : trial[DEN_W-1:0];
         count_in = count_ff + CNT_W'(1);
         if (last) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         count_ff   <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_done     = done_ff;
   assign div_quotient = quo_ff;

endmodule

// ===== design/binomial_coefficient_unit.sv =====
// Binomial coefficient unit: computes C(n,k) for 7-bit unsigned n and k.
// An item is taken on a rising edge with start high and busy low; req_n and
// req_k are sampled there and busy stays high until the item is finished.
// The result appears on rsp_value and rsp_error for exactly one cycle, marked
// by rsp_valid; the receiver cannot hold it off, and busy is already low in
// that cycle, so the next item may be started alongside it.
// When k exceeds n, rsp_error is set and rsp_value is zero in the cycle after
// the item is taken; when k is zero or equal to n the value 1 comes equally
// quickly. Otherwise the block runs j = min(k, n-k) steps, each forming
// C(n,i+1) = C(n,i) * (n-i) / (i+1) with one multiply followed by a bit
// serial divide on the shared divider, which forms WIDE_W = 70 quotient bits
// per step. Above n = 66 a coefficient that does not fit in 63 bits ends the
// run early with rsp_value saturated to all ones. Reset returns the sequencer
// to idle and drops any item in flight; no result is issued for it.
module binomial_coefficient_unit
   import bcu_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [N_W-1:0]   req_n,
   input  logic [N_W-1:0]   req_k,
   output logic             rsp_valid,
   output logic [VALUE_W-1:0] rsp_value,
   output logic             rsp_error
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_LOAD = 2'd2;
   localparam logic [1:0] ST_WAIT = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [N_W-1:0]    n_ff, n_in;
   logic [STEP_W-1:0] i_ff, i_in;
   logic [STEP_W-1:0] j_ff, j_in;
   value_type         prod_ff, prod_in;
   wide_type          wide_ff, wide_in;
   logic              rsp_valid_ff, rsp_valid_in;
   value_type         rsp_value_ff, rsp_value_in;
   logic              rsp_error_ff, rsp_error_in;

   logic              accept;
   logic              k_gt_n;
   logic [N_W-1:0]    n_minus_k;
   logic [STEP_W-1:0] j_new;
   logic [STEP_W-1:0] i_next;
   logic [N_W-1:0]    factor;
   logic              overflow;
   logic              div_start;
   logic              div_done;
   wide_type          div_quotient;

   bcu_divider u_divider (
      .clock        (clock),
      .reset        (reset),
      .div_start    (div_start),
      .div_dividend (wide_ff),
      .div_divisor  (i_next),
      .div_done     (div_done),
      .div_quotient (div_quotient)
   );

   always_comb begin
      accept    = start && !busy;
      k_gt_n    = req_k > req_n;
      n_minus_k = req_n - req_k;
      // With k not above n, the smaller of k and n-k is at most 63.
      j_new     = (req_k > n_minus_k) ? n_minus_k[STEP_W-1:0] : req_k[STEP_W-1:0];
      i_next    = i_ff + STEP_W'(1);
      factor    = n_ff - {1'b0, i_ff};
      // The quotient is exactly C(n,i+1); anything above 63 bits saturates.
      overflow  = |div_quotient[WIDE_W-1:VALUE_W];
      div_start = state_ff == ST_LOAD;
   end

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      prod_in      = prod_ff;
      wide_in      = wide_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      rsp_error_in = rsp_error_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               n_in    = req_n;
               j_in    = j_new;
               i_in    = '0;
               prod_in = VALUE_W'(1);
               if (k_gt_n) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = '0;
                  rsp_error_in = 1'b1;
               end else if (j_new == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = VALUE_W'(1);
                  rsp_error_in = 1'b0;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            wide_in  = WIDE_W'(prod_ff) * WIDE_W'(factor);
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_done) begin
               if (overflow) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = VALUE_MAX;
                  rsp_error_in = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  prod_in = div_quotient[VALUE_W-1:0];
                  if (i_next == j_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_value_in = div_quotient[VALUE_W-1:0];
                     rsp_error_in = 1'b0;
                     state_in     = ST_IDLE;
                  end else begin
                     i_in     = i_next;
                     state_in = ST_MUL;
                  end
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      prod_ff      <= prod_in;
      wide_ff      <= wide_in;
      rsp_value_ff <= rsp_value_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_error = rsp_error_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_value == '0)
      else $error("error result carries a non-zero value");

   assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_k > req_n) |=> rsp_valid && rsp_error && !busy)
      else $error("k above n did not give an immediate error result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result issued while an item is still in progress");

   assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_WAIT)
      else $error("divider finished outside the wait state");
`endif

endmodule
